// ===== src/sla_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sla_pkg
// Shared types and constants of the serial line assembler with echo.
// ----------------------------------------------------------------------------
package sla_pkg;

    localparam int LINE_DEPTH = 32;
    localparam int CNT_W      = $clog2(LINE_DEPTH);

    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_DEL = 8'h7F;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_SP  = 8'h20;

    typedef enum logic [1:0] {
        KIND_ECHO,
        KIND_LINE,
        KIND_OVF
    } kind_t;

    typedef enum logic [1:0] {
        OP_OVF,
        OP_BS,
        OP_EOL,
        OP_CHR
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ECHO,
        ST_LINE_START,
        ST_LINE_OUT
    } state_t;

endpackage

`default_nettype wire

// ===== src/serial_line_assembler_with_echo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// serial_line_assembler_with_echo
// Assembles received bytes into a command line with echo, line editing,
// line readout and overflow reporting.
// ----------------------------------------------------------------------------
// channel   direction  payload
// s_        in         tdata[7:0] rx_byte
// m_        out        tdata[7:0] out_byte, tuser[1:0] out_kind, tlast last
// cfg_      in         wr_data echo_enable
//
// a byte is taken when the sequencer is idle
// echo results follow one per cycle unless m_tready holds them; a line end
// first reads the line store, then gives one stored byte per cycle, as allowed
// the output register frees the input side while the last result waits
// m_tready low holds the sequencer; synchronous reset clears count and state
// ----------------------------------------------------------------------------
module serial_line_assembler_with_echo (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // rx_byte
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,   // out_byte
    output logic      [1:0] m_tuser,   // out_kind
    output logic            m_tlast    // last
);

    import sla_pkg::*;

    localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(LINE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    state_t           state_reg, state_next;
    op_t              op_reg, op_next;
    logic [7:0]       byte_reg, byte_next;
    logic [1:0]       seq_reg, seq_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             echo_reg;

    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_byte_reg;
    kind_t            m_kind_reg;
    logic             m_last_reg;

    logic             in_acc, out_free;
    logic             in_ovf, in_bs, in_eol;
    logic             seq_end, line_end, has_line;

    logic             out_load;
    kind_t            out_kind;
    logic [7:0]       out_byte;
    logic             out_last;
    logic             ram_we, ram_re;
    logic [CNT_W-1:0] ram_raddr;
    logic [7:0]       ram_rdata;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign in_ovf = (fill_reg >= FILL_MAX);
    assign in_bs  = (s_tdata == CH_BS) || (s_tdata == CH_DEL);
    assign in_eol = (s_tdata == CH_CR) || (s_tdata == CH_LF);

    assign has_line = (len_reg != '0);
    assign line_end = (idx_reg == len_reg);

    always_comb begin
        case (op_reg)
            OP_BS:   seq_end = (seq_reg == 2'd2);
            OP_EOL:  seq_end = (seq_reg == 2'd1);
            default: seq_end = 1'b1;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (in_ovf) begin
                        state_next = ST_ECHO;
                    end else if (in_bs) begin
                        if (echo_reg) state_next = ST_ECHO;
                    end else if (in_eol) begin
                        if (echo_reg) state_next = ST_ECHO;
                        else if (fill_reg != '0) state_next = ST_LINE_START;
                    end else begin
                        if (echo_reg) state_next = ST_ECHO;
                    end
                end
            end
            ST_ECHO: begin
                if (out_free && seq_end) begin
                    if (op_reg == OP_EOL && has_line) state_next = ST_LINE_START;
                    else state_next = ST_IDLE;
                end
            end
            ST_LINE_START: begin
                state_next = ST_LINE_OUT;
            end
            ST_LINE_OUT: begin
                if (out_free && line_end) state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath controls
    always_comb begin
        op_next   = op_reg;
        byte_next = byte_reg;
        seq_next  = seq_reg;
        fill_next = fill_reg;
        len_next  = len_reg;
        idx_next  = idx_reg;
        out_load  = 1'b0;
        out_kind  = KIND_ECHO;
        out_byte  = byte_reg;
        out_last  = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = idx_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    byte_next = s_tdata;
                    seq_next  = 2'd0;
                    if (in_ovf) begin
                        op_next   = OP_OVF;
                        fill_next = '0;
                    end else if (in_bs) begin
                        op_next = OP_BS;
                        if (fill_reg != '0) fill_next = fill_reg - CNT_ONE;
                    end else if (in_eol) begin
                        op_next   = OP_EOL;
                        len_next  = fill_reg;
                        fill_next = '0;
                    end else begin
                        op_next   = OP_CHR;
                        ram_we    = 1'b1;
                        fill_next = fill_reg + CNT_ONE;
                    end
                end
            end
            ST_ECHO: begin
                if (out_free) begin
                    out_load = 1'b1;
                    seq_next = seq_reg + 2'd1;
                    case (op_reg)
                        OP_OVF: begin
                            out_kind = KIND_OVF;
                            out_byte = 8'h00;
                        end
                        OP_BS:   out_byte = (seq_reg == 2'd1) ? CH_SP : CH_BS;
                        OP_EOL:  out_byte = (seq_reg == 2'd0) ? CH_CR : CH_LF;
                        default: out_byte = byte_reg;
                    endcase
                    out_last = seq_end && !(op_reg == OP_EOL && has_line);
                end
            end
            ST_LINE_START: begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                idx_next  = CNT_ONE;
            end
            ST_LINE_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_kind = KIND_LINE;
                    out_byte = ram_rdata;
                    out_last = line_end;
                    if (!line_end) begin
                        ram_re   = 1'b1;
                        idx_next = idx_reg + CNT_ONE;
                    end
                end
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    assign m_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            echo_reg    <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) echo_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        byte_reg <= byte_next;
        seq_reg  <= seq_next;
        len_reg  <= len_next;
        idx_reg  <= idx_next;
        if (out_load) begin
            m_kind_reg <= out_kind;
            m_byte_reg <= out_byte;
            m_last_reg <= out_last;
        end
    end

    sla_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (fill_reg),
        .wdata (s_tdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_byte_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    // line store is never written while it is being read out
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("line store written during readout");

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_MAX)
        else $error("fill count beyond line depth");

    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LINE_OUT) |-> (idx_reg <= len_reg && idx_reg != '0))
        else $error("readout index out of range");

    a_readout_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LINE_START) |-> has_line && fill_reg == '0)
        else $error("readout started on empty line");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |=> !$past(out_load))
        else $error("output overwritten while stalled");

endmodule

`default_nettype wire

// ===== src/sla_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sla_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module sla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== dv/sla_line_checker.sv =====
// ----------------------------------------------------------------------------
// sla_line_checker
// Watches the byte input, the result output and the echo register write of
// the serial line assembler. Keeps its own copy of the line store, the fill
// count and the echo setting, works out the results of every accepted byte,
// and compares each result transaction field by field with the oldest one
// still due. Hands the mismatch count and the number of results still due
// to the testbench top.
// ----------------------------------------------------------------------------
module sla_line_checker
    import sla_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,
    input  logic [1:0] m_tuser,
    input  logic       m_tlast,
    output int         mismatches,
    output int         pending
);

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } out_item_t;

    out_item_t  items_due [$];
    logic [7:0] line_mem [LINE_DEPTH];
    int         fill_cnt;
    logic       echo_on;

    initial begin
        mismatches = 0;
        pending    = 0;
        fill_cnt   = 0;
        echo_on    = 1'b1;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < 100) begin
            $display("mismatch at %0t: %s", $time, msg);
        end
        mismatches++;
    endtask

    function automatic void add_item(input kind_t kind, input logic [7:0] data);
        out_item_t it;
        it.kind = kind;
        it.data = data;
        it.last = 1'b0;
        items_due.push_back(it);
    endfunction

    function automatic void edit_line(input logic [7:0] c);
        int base;
        base = items_due.size();
        if (fill_cnt >= LINE_DEPTH - 1) begin
            fill_cnt = 0;
            add_item(KIND_OVF, 8'h00);
        end else if (c == CH_BS || c == CH_DEL) begin
            if (echo_on) begin
                add_item(KIND_ECHO, CH_BS);
                add_item(KIND_ECHO, CH_SP);
                add_item(KIND_ECHO, CH_BS);
            end
            if (fill_cnt > 0) begin
                fill_cnt--;
            end
        end else if (c == CH_CR || c == CH_LF) begin
            if (echo_on) begin
                add_item(KIND_ECHO, CH_CR);
                add_item(KIND_ECHO, CH_LF);
            end
            for (int i = 0; i < fill_cnt; i++) begin
                add_item(KIND_LINE, line_mem[i]);
            end
            fill_cnt = 0;
        end else begin
            if (echo_on) begin
                add_item(KIND_ECHO, c);
            end
            line_mem[fill_cnt] = c;
            fill_cnt++;
        end
        if (items_due.size() > base) begin
            items_due[items_due.size() - 1].last = 1'b1;
        end
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            items_due.delete();
            fill_cnt = 0;
            echo_on  = 1'b1;
        end else begin
            if (cfg_wr_en) begin
                echo_on = cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                edit_line(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                if (items_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected transaction kind %0d byte %02h last %0b",
                                              m_tuser, m_tdata, m_tlast));
                end else begin
                    want = items_due.pop_front();
                    if (m_tuser != want.kind) begin
                        report_mismatch($sformatf("kind got %0d expected %0d",
                                                  m_tuser, want.kind));
                    end
                    if (m_tdata != want.data) begin
                        report_mismatch($sformatf("byte got %02h expected %02h",
                                                  m_tdata, want.data));
                    end
                    if (m_tlast != want.last) begin
                        report_mismatch($sformatf("last got %0b expected %0b",
                                                  m_tlast, want.last));
                    end
                end
            end
        end
        pending = items_due.size();
    end

endmodule

// ===== dv/serial_line_assembler_with_echo_tb.sv =====
// ----------------------------------------------------------------------------
// serial_line_assembler_with_echo_tb
// Feeds the serial line assembler with edited command lines: directed bytes
// for editing, line end and the field extremes, then random lines with
// backspaces, long lines that overflow, unterminated lines and raw bytes,
// with echo switched on and off between phases. Both sides stall in random
// bursts. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module serial_line_assembler_with_echo_tb;
    import sla_pkg::*;

    localparam int HALF_PERIOD  = 10;
    localparam int SETTLE       = LINE_DEPTH + 8;
    localparam int LIMIT_CYCLES = 400000;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       s_tvalid    = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata     = 8'h00;
    logic       m_tvalid;
    logic       m_tready    = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;

    int mismatches;
    int pending;
    bit gaps_on = 1'b1;

    always #HALF_PERIOD aclk = ~aclk;

    serial_line_assembler_with_echo i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    sla_line_checker i_chk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    // result side back-pressure
    initial begin
        forever begin
            @(posedge aclk);
            if (gaps_on && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
            m_tready <= 1'b1;
        end
    end

    initial begin
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("status: fail");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_echo(input logic val);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [7:0] pick_line_byte();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return 8'($urandom_range(8'h20, 8'h7E));
        end else if (roll < 85) begin
            return 8'($urandom_range(0, 255));
        end else begin
            return ($urandom_range(0, 1) == 0) ? CH_BS : CH_DEL;
        end
    endfunction

    task automatic run_lines(input int budget, input bit allow_gaps, input bit first_long);
        int sent;
        int len;
        bit long_next;
        sent      = 0;
        long_next = first_long;
        while (sent < budget) begin
            gaps_on = allow_gaps && ($urandom_range(0, 3) != 0);
            if (long_next || $urandom_range(0, 9) == 0) begin
                len = $urandom_range(LINE_DEPTH - 1, LINE_DEPTH + 4);
            end else begin
                len = $urandom_range(0, 12);
            end
            long_next = 1'b0;
            for (int k = 0; k < len; k++) begin
                send_byte(pick_line_byte());
                sent++;
            end
            // most lines end, some run on into the next
            if ($urandom_range(0, 99) < 85) begin
                send_byte(($urandom_range(0, 1) == 0) ? CH_CR : CH_LF);
                sent++;
            end
            if ($urandom_range(0, 7) == 0) begin
                wait_idle();
            end
        end
    endtask

    initial begin
        logic [7:0] echo_on_bytes [$];
        logic [7:0] echo_off_bytes [$];
        echo_on_bytes  = '{8'h68, 8'h69, CH_DEL, CH_BS, CH_BS, CH_CR,
                           8'h00, 8'hFF, 8'h09, 8'h0B, 8'h0E, 8'h7E, 8'h80, CH_LF,
                           CH_LF, 8'h78, 8'h79, CH_BS, CH_CR};
        echo_off_bytes = '{8'h61, CH_BS, CH_DEL, 8'h62, CH_CR, CH_LF};

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        write_echo(1'b1);
        foreach (echo_on_bytes[i]) begin
            send_byte(echo_on_bytes[i]);
        end
        wait_idle();
        write_echo(1'b0);
        foreach (echo_off_bytes[i]) begin
            send_byte(echo_off_bytes[i]);
        end
        wait_idle();

        write_echo(1'b1);
        run_lines(45, 1'b1, 1'b1);
        wait_idle();
        write_echo(1'b0);
        run_lines(40, 1'b1, 1'b0);
        wait_idle();
        write_echo(1'b1);
        run_lines(40, 1'b0, 1'b1);
        gaps_on = 1'b0;
        wait_idle();

        if (mismatches == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/sla_pkg.sv
src/sla_ram.sv
src/serial_line_assembler_with_echo.sv
dv/sla_line_checker.sv
dv/serial_line_assembler_with_echo_tb.sv
